FILE: design/todsrt_pkg.sv
`timescale 1ns / 1ps
// Package for the time-of-day slot run timer: field widths, event codes and
// the reciprocal constants of the time-of-day split. No dependencies.
package todsrt_pkg;

  localparam int SLOT_W      = 28;
  localparam int SLOT_IDX_W  = 2;
  localparam int MOD_W       = 11;  // minute of day, 0..1439

  // slot word layout
  localparam int ACT_BIT     = 0;
  localparam int HOUR_LO     = 1;
  localparam int HOUR_HI     = 5;
  localparam int MIN_LO      = 6;
  localparam int MIN_HI      = 11;
  localparam int DUR_LO      = 12;
  localparam int DUR_HI      = 27;

  localparam logic [31:0] MS_PER_MIN    = 32'd60000;
  localparam logic [11:0] MIN_PER_HOUR  = 12'd60;
  localparam logic [4:0]  HOURS_PER_DAY = 5'd24;
  localparam logic [5:0]  MINS_PER_HOUR = 6'd60;

  // floor(x / 15) = (x * RECIP15) >> 35 for any 32-bit x
  localparam logic [31:0] RECIP15   = 32'h8888_8889;
  localparam int          SHIFT15   = 35;
  // floor(x / 45) = (x * RECIP45) >> 28 for any 22-bit x
  localparam logic [22:0] RECIP45   = 23'd5965233;
  localparam int          SHIFT45   = 28;
  localparam logic [21:0] DIV45     = 22'd45;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_START  = 2'd1,
    EV_FINISH = 2'd2,
    EV_STOP   = 2'd3
  } event_t;

endpackage

FILE: design/time_of_day_slot_run_timer.sv
`timescale 1ns / 1ps
// Time-of-day slot run timer: epoch split, slot match and run state.
// Depends on todsrt_pkg.
//
// Throughput: one item per cycle while m_tready does not stall the result
// register; the pipe is set by the two reciprocal multiply stages
// (divide by 60, then mod 1440) ahead of the state stage.
// Reset (rst, synchronous): pipeline empty, no run, no suppression, all
// slot words cleared.
module time_of_day_slot_run_timer
  import todsrt_pkg::*;
#(
  parameter int SLOT_COUNT = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [SLOT_IDX_W-1:0] cfg_index,
  input  logic [SLOT_W-1:0]     cfg_data,
  // input items
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [63:0]           s_tdata,  // [31:0] local_epoch_seconds, [63:32] now_ms
  input  logic                  s_tuser,  // [0] stop_request
  // result items
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,  // [1:0] run_slot, [7:2] zero
  output logic [2:0]            m_tuser   // [0] run_active, [2:1] event_code
);

  // ---------------- pipeline control ----------------
  logic v0, v1, v2, v3, ov;
  logic rdy0, rdy1, rdy2, rdy3, out_ld;

  assign rdy3   = !v3 || !ov || m_tready;
  assign rdy2   = !v2 || rdy3;
  assign rdy1   = !v1 || rdy2;
  assign rdy0   = !v0 || rdy1;
  assign out_ld = v3 && (!ov || m_tready);
  assign s_tready = rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (rdy0) v0 <= s_tvalid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (!ov || m_tready) ov <= v3;
    end
  end

  // ---------------- datapath stages ----------------
  logic [31:0] s0_epoch, s0_now;
  logic        s0_stop;
  logic [61:0] s1_prod;
  logic [31:0] s1_now;
  logic        s1_stop;
  logic [44:0] s2_prod;
  logic [21:0] s2_u;
  logic [4:0]  s2_low;
  logic [31:0] s2_now;
  logic        s2_stop;
  logic [MOD_W-1:0] s3_mod;
  logic [31:0] s3_now;
  logic        s3_stop;

  logic [26:0] q1;        // epoch / 60
  logic [16:0] t45;
  logic [21:0] rem45;

  assign q1    = s1_prod[SHIFT15 +: 27];
  assign t45   = s2_prod[SHIFT45 +: 17];
  assign rem45 = s2_u - 22'(22'(t45) * DIV45);

  always_ff @(posedge clk) begin
    if (rdy0) begin
      s0_epoch <= s_tdata[31:0];
      s0_now   <= s_tdata[63:32];
      s0_stop  <= s_tuser;
    end
    if (rdy1) begin
      // epoch / 60 = (epoch / 4) / 15
      s1_prod <= 62'(s0_epoch[31:2]) * 62'(RECIP15);
      s1_now  <= s0_now;
      s1_stop <= s0_stop;
    end
    if (rdy2) begin
      // q1 mod 1440 = 32 * ((q1 >> 5) mod 45) + q1[4:0]
      s2_prod <= 45'(q1[26:5]) * 45'(RECIP45);
      s2_u    <= q1[26:5];
      s2_low  <= q1[4:0];
      s2_now  <= s1_now;
      s2_stop <= s1_stop;
    end
    if (rdy3) begin
      s3_mod  <= {rem45[5:0], s2_low};
      s3_now  <= s2_now;
      s3_stop <= s2_stop;
    end
  end

  // ---------------- slot registers ----------------
  logic [SLOT_W-1:0] slot_word [SLOT_COUNT];
  logic [31:0]       slot_tgt  [SLOT_COUNT];  // duration in ms

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (rst) begin
        slot_word[i] <= '0;
        slot_tgt[i]  <= '0;
      end else begin
        if (cfg_we && cfg_index == SLOT_IDX_W'(i)) slot_word[i] <= cfg_data;
        slot_tgt[i] <= 32'(slot_word[i][DUR_HI:DUR_LO]) * MS_PER_MIN;
      end
    end
  end

  // ---------------- run state ----------------
  logic                  running, running_next;
  logic [SLOT_IDX_W-1:0] active_slot, active_slot_next;
  logic [31:0]           run_start_ms, run_start_ms_next;
  logic                  suppress_valid, suppress_valid_next;
  logic [MOD_W-1:0]      suppress_minute, suppress_minute_next;
  event_t                ev;
  logic [SLOT_COUNT-1:0] slot_hit;
  logic [31:0]           elapsed;
  logic [31:0]           cur_tgt;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_hit[i] = slot_word[i][ACT_BIT]
                 && slot_word[i][HOUR_HI:HOUR_LO] < HOURS_PER_DAY
                 && slot_word[i][MIN_HI:MIN_LO] < MINS_PER_HOUR
                 && (12'(slot_word[i][HOUR_HI:HOUR_LO]) * MIN_PER_HOUR
                     + 12'(slot_word[i][MIN_HI:MIN_LO])) == 12'(s3_mod);
    end
  end

  always_comb begin
    cur_tgt = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (active_slot == SLOT_IDX_W'(i)) cur_tgt = slot_tgt[i];
    end
  end

  assign elapsed = s3_now - run_start_ms;

  always_comb begin
    logic found;
    running_next         = running;
    active_slot_next     = active_slot;
    run_start_ms_next    = run_start_ms;
    suppress_valid_next  = suppress_valid;
    suppress_minute_next = suppress_minute;
    ev                   = EV_NONE;
    found                = 1'b0;

    if (s3_stop && running) begin
      suppress_valid_next  = 1'b1;
      suppress_minute_next = s3_mod;
      running_next         = 1'b0;
      active_slot_next     = '0;
      ev                   = EV_STOP;
    end

    // suppression lapses once the minute of day moves on
    if (suppress_valid_next && s3_mod != suppress_minute_next) suppress_valid_next = 1'b0;

    if (!running_next) begin
      if (!(suppress_valid_next && s3_mod == suppress_minute_next)) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (slot_hit[i] && !found) begin
            found             = 1'b1;
            running_next      = 1'b1;
            active_slot_next  = SLOT_IDX_W'(i);
            run_start_ms_next = s3_now;
            ev                = EV_START;
          end
        end
      end
    end else if (elapsed >= cur_tgt) begin
      running_next     = 1'b0;
      active_slot_next = '0;
      ev               = EV_FINISH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running         <= 1'b0;
      active_slot     <= '0;
      run_start_ms    <= '0;
      suppress_valid  <= 1'b0;
      suppress_minute <= '0;
    end else if (out_ld) begin
      running         <= running_next;
      active_slot     <= active_slot_next;
      run_start_ms    <= run_start_ms_next;
      suppress_valid  <= suppress_valid_next;
      suppress_minute <= suppress_minute_next;
    end
  end

  // ---------------- result register ----------------
  logic                  out_run;
  logic [SLOT_IDX_W-1:0] out_slot;
  event_t                out_ev;

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_run  <= running_next;
      out_slot <= running_next ? active_slot_next : '0;
      out_ev   <= ev;
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = {6'd0, out_slot};
  assign m_tuser  = {out_ev, out_run};

  // ---------------- assertions ----------------
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    ov && out_ev == EV_START |-> out_run)
    else $error("start item without run flag");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    ov && (out_ev == EV_FINISH || out_ev == EV_STOP) |-> !out_run && out_slot == '0)
    else $error("finish or stop item still shows a run");

  a_idle_slot: assert property (@(posedge clk) disable iff (rst)
    !running |-> active_slot == '0)
    else $error("idle with nonzero slot");

  a_state_tracks_out: assert property (@(posedge clk) disable iff (rst)
    out_ld |=> running == out_run)
    else $error("run state and result item disagree");

endmodule
